>>> src/open_address_hash_table_unit_macros.svh
// Assertion macros for the open-address hash table checker.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef OPEN_ADDRESS_HASH_TABLE_UNIT_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define OAHT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oaht checker: same-cycle rule violated");

// next-cycle implication, off during reset
`define OAHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oaht checker: next-cycle rule violated");

`endif

>>> src/oaht_pkg.sv
// Shared types and constants for the open-address hash table unit.
// No dependencies.
package oaht_pkg;

	localparam int SLOTS_DEF = 256;
	localparam int CMD_W     = 2;
	localparam int KEY_W     = 32;
	localparam int HASH_W    = 32;
	localparam int VAL_W     = 64;
	localparam int LIMIT_W   = 8;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 2;

	// slot word: {tombstone, key, value}
	localparam int ENTRY_W   = 1 + KEY_W + VAL_W;
	localparam int VAL_LSB   = 0;
	localparam int KEY_LSB   = VAL_W;
	localparam int TOMB_BIT  = VAL_W + KEY_W;

	localparam logic [CMD_W-1:0] CMD_GET = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

	localparam logic [PADDR_W-1:0] REG_LOAD_LIMIT = 2'd0;
	localparam logic [LIMIT_W-1:0] LIMIT_RST      = 8'd192;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic ld_item;
		logic hash_step;
		logic probe_start;
		logic probe_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic item_null;
		logic hash_done;
		logic probe_done;
		logic out_free;
	} dp_stat_t;

endpackage

>>> src/open_address_hash_table_unit.sv
// Top level of the open-address hash table unit: APB register, controller,
// datapath. Depends on oaht_pkg, oaht_ctrl, oaht_dp (and oaht_ram below it).
//
// Fixed-capacity key/value table, SLOTS entries, open addressing with linear
// probing and tombstones. Each item is a get, set or delete with a nonzero
// key_id and its precomputed key_hash; exactly one result item comes back per
// item, in order. The probe starts at key_hash mod SLOTS and reads one slot
// per cycle from a single-port-read slot RAM until it meets the key, a truly
// empty slot, or has seen every slot. When SLOTS is a power of two the start
// slot is taken straight from the hash; for other SLOTS values it comes from a
// reciprocal multiply and one correction. One item is in work at a time; the
// result register lets the next item be accepted while a result still waits
// on out_stall. After reset the unit sweeps the slot RAM to zero, one entry
// per cycle, and holds in_stall high meanwhile; the load_limit register can
// be written during the sweep. A set that needs a fresh slot while the
// occupied count (tombstones included) has reached load_limit is refused with
// full_res. load_limit lives at byte address 0 and may only be written while
// the unit is idle.
module open_address_hash_table_unit #(
	parameter int SLOTS = oaht_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// item in
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [oaht_pkg::CMD_W-1:0]        cmd,
	input  logic [oaht_pkg::KEY_W-1:0]        key_id,
	input  logic [oaht_pkg::HASH_W-1:0]       key_hash,
	input  logic [oaht_pkg::VAL_W-1:0]        value_in,
	// result out
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [oaht_pkg::VAL_W-1:0]        value_out,
	output logic                              full_res,
	// APB config
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [oaht_pkg::PADDR_W-1:0]      paddr,
	input  logic [oaht_pkg::PDATA_W-1:0]      pwdata,
	output logic [oaht_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);

	// load limit register; writes to other addresses are dropped
	logic [oaht_pkg::LIMIT_W-1:0] load_limit_q;
	logic                         limit_wr;

	assign pready   = 1'b1;
	assign limit_wr = psel && penable && pwrite && (paddr == oaht_pkg::REG_LOAD_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_limit_q <= oaht_pkg::LIMIT_RST;
		end else if (limit_wr) begin
			load_limit_q <= pwdata[oaht_pkg::LIMIT_W-1:0];
		end
	end

	assign prdata = (paddr == oaht_pkg::REG_LOAD_LIMIT) ?
		oaht_pkg::PDATA_W'(load_limit_q) : '0;

	// controller / datapath split: commands down, status up
	oaht_pkg::ctrl_cmd_t ctrl_cmd;
	oaht_pkg::dp_stat_t  dp_stat;

	oaht_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (dp_stat),
		.cmd_o   (ctrl_cmd)
	);

	oaht_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_i     (ctrl_cmd),
		.stat      (dp_stat),
		.load_limit(load_limit_q),
		.cmd       (cmd),
		.key_id    (key_id),
		.key_hash  (key_hash),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.value_out (value_out),
		.full_res  (full_res)
	);

endmodule

>>> src/oaht_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/oaht_ctrl.sv
// Sequencing state machine for the hash table: clear, hash, probe, commit.
// Depends on oaht_pkg.
module oaht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  oaht_pkg::dp_stat_t stat,
	output oaht_pkg::ctrl_cmd_t cmd_o
);

	oaht_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oaht_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oaht_pkg::S_CLEAR: begin
				if (stat.clr_last) state_d = oaht_pkg::S_IDLE;
			end
			oaht_pkg::S_IDLE: begin
				if (in_valid) state_d = oaht_pkg::S_HASH;
			end
			oaht_pkg::S_HASH: begin
				if (stat.item_null) state_d = oaht_pkg::S_COMMIT;
				else if (stat.hash_done) state_d = oaht_pkg::S_PROBE;
			end
			oaht_pkg::S_PROBE: begin
				if (stat.probe_done) state_d = oaht_pkg::S_COMMIT;
			end
			oaht_pkg::S_COMMIT: begin
				if (stat.out_free) state_d = oaht_pkg::S_IDLE;
			end
			default: state_d = oaht_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd_o    = '0;
		in_stall = 1'b1;
		unique case (state_q)
			oaht_pkg::S_CLEAR: begin
				cmd_o.clr_wr = 1'b1;
			end
			oaht_pkg::S_IDLE: begin
				in_stall     = 1'b0;
				cmd_o.ld_item = in_valid;
			end
			oaht_pkg::S_HASH: begin
				cmd_o.hash_step   = !stat.item_null && !stat.hash_done;
				cmd_o.probe_start = !stat.item_null && stat.hash_done;
			end
			oaht_pkg::S_PROBE: begin
				cmd_o.probe_step = 1'b1;
			end
			oaht_pkg::S_COMMIT: begin
				cmd_o.commit = stat.out_free;
			end
			default: begin
				cmd_o = '0;
			end
		endcase
	end

endmodule

>>> src/oaht_dp.sv
// Datapath: item registers, start-slot reduction, probe walker, slot RAM,
// occupancy count and the output register. Depends on oaht_pkg, oaht_ram.
module oaht_dp #(
	parameter int SLOTS = oaht_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  oaht_pkg::ctrl_cmd_t               cmd_i,
	output oaht_pkg::dp_stat_t                stat,
	input  logic [oaht_pkg::LIMIT_W-1:0]      load_limit,
	input  logic [oaht_pkg::CMD_W-1:0]        cmd,
	input  logic [oaht_pkg::KEY_W-1:0]        key_id,
	input  logic [oaht_pkg::HASH_W-1:0]       key_hash,
	input  logic [oaht_pkg::VAL_W-1:0]        value_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [oaht_pkg::VAL_W-1:0]        value_out,
	output logic                              full_res
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (CNT_W > oaht_pkg::LIMIT_W) ? CNT_W : oaht_pkg::LIMIT_W;
	localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// item
	logic [oaht_pkg::CMD_W-1:0]  cmd_q;
	logic [oaht_pkg::KEY_W-1:0]  key_q;
	logic [oaht_pkg::HASH_W-1:0] hash_q;
	logic [oaht_pkg::VAL_W-1:0]  val_q;

	always_ff @(posedge clk) begin
		if (cmd_i.ld_item) begin
			cmd_q  <= cmd;
			key_q  <= key_id;
			hash_q <= key_hash;
			val_q  <= value_in;
		end
	end

	logic item_null;
	assign item_null = (key_q == '0) ||
		!((cmd_q == oaht_pkg::CMD_GET) || (cmd_q == oaht_pkg::CMD_SET) ||
		  (cmd_q == oaht_pkg::CMD_DEL));

	// start slot = hash mod SLOTS
	logic [IDX_W-1:0] start_idx;
	logic             hash_done;

	generate
		if (IS_POW2) begin : g_mask
			assign start_idx = hash_q[IDX_W-1:0];
			assign hash_done = 1'b1;
		end else begin : g_rem
			// quotient estimate by reciprocal multiply, low by at most one:
			// first step hash * RECIP, second step hash - quot * SLOTS, then one
			// compare-subtract on the way out
			localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SLOTS));

			logic [63:0]    prod_q;
			logic [IDX_W:0] rem_q;
			logic [1:0]     mstep_q;
			logic [31:0]    quot;
			logic [31:0]    quot_x_slots;
			logic [IDX_W:0] rem_sub;

			assign quot         = prod_q[63:32];
			assign quot_x_slots = quot * 32'(SLOTS);
			assign rem_sub      = rem_q - (IDX_W + 1)'(SLOTS);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mstep_q <= '0;
				end else if (cmd_i.ld_item) begin
					mstep_q <= '0;
				end else if (cmd_i.hash_step) begin
					mstep_q <= mstep_q + 2'd1;
				end
			end

			always_ff @(posedge clk) begin
				if (cmd_i.hash_step) begin
					if (mstep_q == 2'd0) begin
						prod_q <= 64'(hash_q) * 64'(RECIP);
					end else begin
						rem_q <= hash_q[IDX_W:0] - quot_x_slots[IDX_W:0];
					end
				end
			end

			assign start_idx = (rem_q >= (IDX_W + 1)'(SLOTS)) ? rem_sub[IDX_W-1:0]
				: rem_q[IDX_W-1:0];
			assign hash_done = (mstep_q == 2'd2);
		end
	endgenerate

	// clear sweep
	logic [IDX_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd_i.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// probe walker
	logic [IDX_W-1:0]            cur_q, n_q, tomb_q, next_idx;
	logic                        have_tomb_q;
	logic [oaht_pkg::ENTRY_W-1:0] rdata;
	logic [oaht_pkg::KEY_W-1:0]  e_key;
	logic                        e_tomb;
	logic                        slot_empty, slot_tomb, slot_match, probe_last, probe_done;
	logic [IDX_W-1:0]            pos_d;
	logic                        avail_d, use_tomb_d;

	assign e_key  = rdata[oaht_pkg::KEY_LSB +: oaht_pkg::KEY_W];
	assign e_tomb = rdata[oaht_pkg::TOMB_BIT];

	assign slot_empty = (e_key == '0) && !e_tomb;
	assign slot_tomb  = (e_key == '0) && e_tomb;
	assign slot_match = (e_key == key_q) && (e_key != '0);
	assign probe_last = (n_q == LAST_IDX);
	assign probe_done = slot_match || slot_empty || probe_last;
	assign next_idx   = (cur_q == LAST_IDX) ? '0 : cur_q + 1'b1;

	always_comb begin
		if (slot_match) begin
			pos_d      = cur_q;
			avail_d    = 1'b1;
			use_tomb_d = 1'b0;
		end else if (slot_empty) begin
			pos_d      = have_tomb_q ? tomb_q : cur_q;
			avail_d    = 1'b1;
			use_tomb_d = have_tomb_q;
		end else begin
			// every slot visited
			pos_d      = have_tomb_q ? tomb_q : cur_q;
			avail_d    = have_tomb_q || slot_tomb;
			use_tomb_d = have_tomb_q || slot_tomb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_tomb_q <= 1'b0;
		end else if (cmd_i.probe_start) begin
			have_tomb_q <= 1'b0;
		end else if (cmd_i.probe_step && slot_tomb) begin
			have_tomb_q <= 1'b1;
		end
	end

	logic                       found_q, avail_q, use_tomb_q;
	logic [IDX_W-1:0]           pos_q;
	logic [oaht_pkg::VAL_W-1:0] val_rd_q;

	always_ff @(posedge clk) begin
		if (cmd_i.probe_start) begin
			cur_q <= start_idx;
			n_q   <= '0;
		end else if (cmd_i.probe_step) begin
			if (!probe_done) begin
				cur_q <= next_idx;
				n_q   <= n_q + 1'b1;
			end
			if (slot_tomb && !have_tomb_q) begin
				tomb_q <= cur_q;
			end
			if (probe_done) begin
				found_q    <= slot_match;
				avail_q    <= avail_d;
				use_tomb_q <= use_tomb_d;
				pos_q      <= pos_d;
				val_rd_q   <= rdata[oaht_pkg::VAL_LSB +: oaht_pkg::VAL_W];
			end
		end
	end

	// commit decision
	logic [CNT_W-1:0]             occ_q;
	logic                         at_limit;
	logic                         c_hit, c_full, c_wr, c_inc;
	logic [oaht_pkg::VAL_W-1:0]   c_vout;
	logic [oaht_pkg::ENTRY_W-1:0] c_wdata;

	assign at_limit = (CMP_W'(occ_q) >= CMP_W'(load_limit));

	always_comb begin
		c_hit   = 1'b0;
		c_full  = 1'b0;
		c_wr    = 1'b0;
		c_inc   = 1'b0;
		c_vout  = '0;
		c_wdata = {1'b0, key_q, val_q};
		if (!item_null) begin
			case (cmd_q)
				oaht_pkg::CMD_GET: begin
					c_hit  = found_q;
					c_vout = found_q ? val_rd_q : '0;
				end
				oaht_pkg::CMD_SET: begin
					if (found_q) begin
						c_wr = 1'b1;
					end else if (!avail_q) begin
						c_full = 1'b1;
					end else if (use_tomb_q) begin
						c_wr  = 1'b1;
						c_hit = 1'b1;
					end else if (at_limit) begin
						c_full = 1'b1;
					end else begin
						c_wr  = 1'b1;
						c_inc = 1'b1;
						c_hit = 1'b1;
					end
				end
				oaht_pkg::CMD_DEL: begin
					c_wdata = {1'b1, {oaht_pkg::KEY_W{1'b0}}, {oaht_pkg::VAL_W{1'b0}}};
					c_wr    = found_q;
					c_hit   = found_q;
				end
				default: begin
					c_hit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd_i.commit && c_inc) begin
			occ_q <= occ_q + 1'b1;
		end
	end

	// slot store
	logic                         ram_we, ram_re;
	logic [IDX_W-1:0]             ram_waddr, ram_raddr;
	logic [oaht_pkg::ENTRY_W-1:0] ram_wdata;

	assign ram_we    = cmd_i.clr_wr || (cmd_i.commit && c_wr);
	assign ram_waddr = cmd_i.clr_wr ? clr_q : pos_q;
	assign ram_wdata = cmd_i.clr_wr ? '0 : c_wdata;
	assign ram_re    = cmd_i.probe_start || (cmd_i.probe_step && !probe_done);
	assign ram_raddr = cmd_i.probe_start ? start_idx : next_idx;

	oaht_ram #(
		.WIDTH(oaht_pkg::ENTRY_W),
		.DEPTH(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.commit) begin
			hit       <= c_hit;
			value_out <= c_vout;
			full_res  <= c_full;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.clr_last   = (clr_q == LAST_IDX);
	assign stat.item_null  = item_null;
	assign stat.hash_done  = hash_done;
	assign stat.probe_done = probe_done;
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule

>>> src/oaht_checker.sv
// Port-level checks for the open-address hash table unit, bound to the top.
// Depends on oaht_pkg and open_address_hash_table_unit_macros.svh.
`include "open_address_hash_table_unit_macros.svh"

module oaht_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       hit,
	input logic [oaht_pkg::VAL_W-1:0] value_out,
	input logic                       full_res
);

	// a held result keeps its payload
	`OAHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(hit) && $stable(value_out) && $stable(full_res))

	// a refused set never reports a hit
	`OAHT_ASSERT_NOW(a_hit_full_excl, out_valid, !(hit && full_res))

	// a nonzero value only comes with a get hit
	`OAHT_ASSERT_NOW(a_value_needs_hit, out_valid && (value_out != '0), hit && !full_res)

	// one item at a time: busy right after an accept
	`OAHT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind open_address_hash_table_unit oaht_checker u_oaht_checker (.*);

>>> tb/sv/open_address_hash_table_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for open_address_hash_table_unit: directed and random
// get/set/delete items checked against a behavioral copy of the table. Needs oaht_pkg.
module open_address_hash_table_unit_test;

	localparam int SLOTS   = oaht_pkg::SLOTS_DEF;
	localparam int CMD_W   = oaht_pkg::CMD_W;
	localparam int KEY_W   = oaht_pkg::KEY_W;
	localparam int HASH_W  = oaht_pkg::HASH_W;
	localparam int VAL_W   = oaht_pkg::VAL_W;
	localparam int LIMIT_W = oaht_pkg::LIMIT_W;
	localparam int PADDR_W = oaht_pkg::PADDR_W;
	localparam int PDATA_W = oaht_pkg::PDATA_W;
	localparam logic [CMD_W-1:0]   CMD_GET        = oaht_pkg::CMD_GET;
	localparam logic [CMD_W-1:0]   CMD_SET        = oaht_pkg::CMD_SET;
	localparam logic [CMD_W-1:0]   CMD_DEL        = oaht_pkg::CMD_DEL;
	localparam logic [PADDR_W-1:0] REG_LOAD_LIMIT = oaht_pkg::REG_LOAD_LIMIT;
	localparam logic [LIMIT_W-1:0] LIMIT_RST      = oaht_pkg::LIMIT_RST;
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;	// unused opcode, block ignores it
	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 4;
	// worst quiet stretch: post-reset sweep, a full-table probe, long output hold-off
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = SLOTS + 40;	// one full probe plus margin
	localparam int POOL_SIZE      = 320;
	localparam int HOLD_AT        = 400;	// result count that triggers the long hold-off
	localparam int HOLD_CYCLES    = 200;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] hash;
		logic [VAL_W-1:0]  value;
	} table_op_t;

	typedef struct {
		logic             hit;
		logic [VAL_W-1:0] value;
		logic             full;
	} table_reply_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd      = CMD_GET;
	logic [KEY_W-1:0]    key_id   = '0;
	logic [HASH_W-1:0]   key_hash = '0;
	logic [VAL_W-1:0]    value_in = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                hit;
	logic [VAL_W-1:0]    value_out;
	logic                full_res;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [PADDR_W-1:0]  paddr   = '0;
	logic [PDATA_W-1:0]  pwdata  = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Behavioral copy of the table: keys, values, tombstones, occupancy, limit
	logic [KEY_W-1:0]    tbl_key  [SLOTS];
	logic [VAL_W-1:0]    tbl_val  [SLOTS];
	logic                tbl_tomb [SLOTS];
	int unsigned         tbl_used;
	logic [LIMIT_W-1:0]  tbl_limit;

	table_op_t           pending_ops[$];		// items waiting to be offered
	table_reply_t        expected_replies[$];	// predicted results, oldest first
	table_op_t           next_op;
	table_reply_t        want;

	logic [KEY_W-1:0]    pool_key  [POOL_SIZE];
	logic [HASH_W-1:0]   pool_hash [POOL_SIZE];

	int in_idle_pct  = 0;
	int out_idle_pct = 0;
	int in_gap_left;
	int out_gap_left;
	int hold_left;
	bit hold_done;
	int replies_seen;
	int quiet_cycles = 0;
	int mismatch_count = 0;

	always #HALF_PERIOD clk = ~clk;

	open_address_hash_table_unit #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.key_id   (key_id),
		.key_hash (key_hash),
		.value_in (value_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit      (hit),
		.value_out(value_out),
		.full_res (full_res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Applies one item to the table copy and returns the result it must produce.
	// Linear probe from hash mod SLOTS; stops on the key or a never-used slot and
	// remembers the first tombstone seen on the way.
	function automatic table_reply_t apply_table_op(table_op_t op);
		table_reply_t rep;
		int           idx;
		int           pos;
		int           tomb_idx;
		bit           have_tomb;
		bit           found;
		bit           avail;
		bit           stop;
		rep = '{hit: 1'b0, value: '0, full: 1'b0};
		// key zero and the unused opcode do nothing and return all zeros
		if (op.key == '0 || op.cmd == CMD_NOP)
			return rep;
		idx = int'(op.hash % SLOTS);
		pos = 0;
		tomb_idx = 0;
		have_tomb = 1'b0;
		found = 1'b0;
		avail = 1'b0;
		stop = 1'b0;
		for (int n = 0; n < SLOTS && !stop; n++) begin
			if (tbl_key[idx] == '0) begin
				if (!tbl_tomb[idx]) begin
					pos = have_tomb ? tomb_idx : idx;
					avail = 1'b1;
					stop = 1'b1;
				end else if (!have_tomb) begin
					have_tomb = 1'b1;
					tomb_idx = idx;
				end
			end else if (tbl_key[idx] == op.key) begin
				pos = idx;
				found = 1'b1;
				avail = 1'b1;
				stop = 1'b1;
			end
			idx = (idx + 1) % SLOTS;
		end
		// whole table walked: only a tombstone can take a new key
		if (!stop) begin
			pos = tomb_idx;
			avail = have_tomb;
		end
		case (op.cmd)
			CMD_GET: begin
				if (found) begin
					rep.hit = 1'b1;
					rep.value = tbl_val[pos];
				end
			end
			CMD_SET: begin
				if (found) begin
					// update in place: never refused, not a new key
					tbl_val[pos] = op.value;
				end else if (!avail) begin
					rep.full = 1'b1;
				end else if (tbl_tomb[pos]) begin
					// tombstone reuse ignores the load limit, count unchanged
					tbl_tomb[pos] = 1'b0;
					tbl_key[pos] = op.key;
					tbl_val[pos] = op.value;
					rep.hit = 1'b1;
				end else if (tbl_used + 1 > tbl_limit) begin
					rep.full = 1'b1;
				end else begin
					tbl_key[pos] = op.key;
					tbl_val[pos] = op.value;
					tbl_used++;
					rep.hit = 1'b1;
				end
			end
			CMD_DEL: begin
				// delete leaves a tombstone, occupancy stays
				if (found) begin
					tbl_key[pos] = '0;
					tbl_val[pos] = '0;
					tbl_tomb[pos] = 1'b1;
					rep.hit = 1'b1;
				end
			end
			default: ;
		endcase
		return rep;
	endfunction

	// Item driver: predicts each accepted item, then offers the next pending one
	// or idles for a random burst. A stalled item is held unchanged.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_replies.push_back(
					apply_table_op(table_op_t'{cmd, key_id, key_hash, value_in}));
			if (!(in_valid && in_stall)) begin
				if (in_gap_left != 0) begin
					in_gap_left--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() != 0 &&
						$urandom_range(0, 99) < in_idle_pct) begin
					// start an idle burst that includes this one
					in_gap_left = $urandom_range(0, 8);
					in_valid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					next_op = pending_ops.pop_front();
					cmd      <= next_op.cmd;
					key_id   <= next_op.key;
					key_hash <= next_op.hash;
					value_in <= next_op.value;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver: checks each accepted result against the oldest
	// prediction, then drives out_stall (random bursts plus one long hold-off
	// that backs the block up into its input).
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap_left = 0;
			hold_left = 0;
			hold_done = 1'b0;
			replies_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				replies_seen++;
				if (expected_replies.size() == 0) begin
					$error("result item with no item outstanding");
					mismatch_count++;
				end else begin
					want = expected_replies.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, hit);
						mismatch_count++;
					end
					if (value_out !== want.value) begin
						$error("value_out: expected %h, got %h", want.value, value_out);
						mismatch_count++;
					end
					if (full_res !== want.full) begin
						$error("full_res: expected %0d, got %0d", want.full, full_res);
						mismatch_count++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && replies_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (out_gap_left != 0) begin
				out_gap_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < out_idle_pct) begin
				out_gap_left = $urandom_range(0, 8);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too long without any item moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_op(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
			input logic [HASH_W-1:0] h, input logic [VAL_W-1:0] v);
		pending_ops.push_back(table_op_t'{c, k, h, v});
	endtask

	// APB write of load_limit (setup + access), then a read back of the same
	// register. Only called with nothing in flight.
	task automatic program_load_limit(input logic [LIMIT_W-1:0] limit);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_LOAD_LIMIT;
		pwdata  <= PDATA_W'(limit);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tbl_limit = limit;
		// psel stays high: this edge starts the read setup
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[LIMIT_W-1:0] !== limit) begin
			$error("load_limit: expected %0d, got %0d", limit, prdata[LIMIT_W-1:0]);
			mismatch_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Sampled at the falling edge so queue updates of the rising edge are settled
	task automatic wait_until_drained();
		do @(negedge clk);
		while (pending_ops.size() != 0 || in_valid || expected_replies.size() != 0);
	endtask

	// Random items: mostly well-formed ops on pooled keys with their own hash,
	// the rest noise (key zero, unused opcode, wrong hash, stray keys).
	// Ignored items do not count toward n.
	task automatic queue_random_ops(input int n, input int span);
		int               counted;
		int               r;
		int               w;
		int               k;
		logic [CMD_W-1:0] c;
		counted = 0;
		while (counted < n) begin
			r = $urandom_range(0, 99);
			w = $urandom_range(0, 99);
			k = $urandom_range(0, span - 1);
			c = (w < 35) ? CMD_GET : (w < 75) ? CMD_SET : CMD_DEL;
			if (r < 80) begin
				queue_op(c, pool_key[k], pool_hash[k], {$urandom, $urandom});
				counted++;
			end else if (r < 84) begin
				queue_op(CMD_NOP, pool_key[k], pool_hash[k], {$urandom, $urandom});
			end else if (r < 88) begin
				queue_op(CMD_W'($urandom_range(0, 3)), '0, $urandom, {$urandom, $urandom});
			end else if (r < 95) begin
				// known key probed from the wrong start slot
				queue_op(c, pool_key[k], $urandom, {$urandom, $urandom});
				counted++;
			end else begin
				queue_op(c, $urandom | 32'h1, $urandom, {$urandom, $urandom});
				counted++;
			end
		end
	endtask

	task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int in_pct,
			input int out_pct, input int n, input int span);
		program_load_limit(limit);
		in_idle_pct = in_pct;
		out_idle_pct = out_pct;
		queue_random_ops(n, span);
		wait_until_drained();
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_key[i] = '0;
			tbl_val[i] = '0;
			tbl_tomb[i] = 1'b0;
		end
		tbl_used = 0;
		tbl_limit = LIMIT_RST;
		// key pool: half the hashes crowd into start slots 0..15 to build chains
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_key[i] = $urandom;
			if (pool_key[i] == '0)
				pool_key[i] = 32'h1;
			pool_hash[i] = $urandom;
			if (i % 2)
				pool_hash[i][7:0] = $urandom_range(0, 15);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, load limit of three. Written during the clearing sweep.
		program_load_limit(8'd3);
		in_idle_pct = 20;
		out_idle_pct = 20;
		queue_op(CMD_GET, 32'h1, 32'h0, '0);				// miss on empty table
		queue_op(CMD_SET, 32'h1, 32'h0, '1);				// new key, slot 0
		queue_op(CMD_GET, 32'h1, 32'h0, '0);
		queue_op(CMD_SET, 32'h1, 32'h0, 64'h5);				// update existing key
		queue_op(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);	// top slot
		queue_op(CMD_SET, 32'h2, 32'h100, 64'hA5A5_5A5A_0F0F_F0F0);	// collides, slot 1
		queue_op(CMD_SET, 32'h3, 32'h0, 64'h7);				// refused: limit reached
		queue_op(CMD_GET, 32'h2, 32'h0, '0);				// found along the chain
		queue_op(CMD_DEL, 32'h1, 32'h0, '0);				// leaves a tombstone
		queue_op(CMD_GET, 32'h2, 32'h0, '0);				// probe passes the tombstone
		queue_op(CMD_SET, 32'h3, 32'h0, 64'h9);				// reuses tombstone at full load
		queue_op(CMD_DEL, 32'h3, 32'h0, '0);
		queue_op(CMD_DEL, 32'h3, 32'h0, '0);				// second delete misses
		queue_op(CMD_SET, 32'h2, 32'h0, 64'h1234);			// update past a tombstone
		queue_op(CMD_SET, 32'h4, 32'hFF, 64'h55);			// wraps into the tombstone
		queue_op(CMD_GET, 32'h4, 32'hFF, '0);				// wrapped lookup
		queue_op(CMD_GET, 32'h0, 32'h0, '0);				// key zero is ignored
		queue_op(CMD_SET, 32'h0, 32'h0, '1);
		queue_op(CMD_DEL, 32'h0, 32'hFF, '0);
		queue_op(CMD_NOP, 32'h2, 32'h0, '1);				// unused opcode
		queue_op(CMD_GET, 32'h5, 32'h0, '0);				// miss through a chain
		queue_op(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		wait_until_drained();

		// Random phases, occupancy only grows; low limit first, extremes included
		run_phase(8'd1,   15, 15, 150, 40);
		run_phase(8'd16,  25,  0, 150, 80);
		run_phase(8'd64,   0, 25, 180, 150);	// long output hold-off lands here
		run_phase(8'd128, 10, 10, 180, 220);
		run_phase(8'd192, 20, 20, 180, 280);
		run_phase(8'd255,  0,  0, 160, POOL_SIZE);	// last part: no idling

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$error("%0d predicted results never arrived", expected_replies.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/oaht_pkg.sv
src/oaht_ram.sv
src/oaht_ctrl.sv
src/oaht_dp.sv
src/open_address_hash_table_unit.sv
src/oaht_checker.sv
tb/sv/open_address_hash_table_unit_test.sv
